>>> hw/rtl/sird_pkg.sv
// ----------------------------------------------------------------------------
// sird_pkg
// Shared types, constants and alphabet helpers for the radix digit converter.
// ----------------------------------------------------------------------------
package sird_pkg;

	localparam int MAX_BASE    = 16;
	localparam int VALUE_W     = 32;
	localparam int LEN_W       = 5;
	localparam int DIGIT_W     = 4;
	localparam int NUM_DIGITS  = 32;
	localparam int DIDX_W      = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TILDE = 8'd126;
	localparam logic [LEN_W-1:0] MIN_RADIX = 5'd2;
	localparam logic [LEN_W-1:0] MAX_RADIX = LEN_W'(MAX_BASE);

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [63:0]      chars_low;
		logic [63:0]      chars_high;
	} cfg_t;

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	function automatic logic [7:0] char_at(input cfg_t cfg, input logic [DIGIT_W-1:0] idx);
		logic [127:0] all_chars;
		all_chars = {cfg.chars_high, cfg.chars_low};
		return all_chars[{idx, 3'b000} +: 8];
	endfunction

	function automatic logic alphabet_ok(input cfg_t cfg);
		logic       ok;
		logic [7:0] ci;
		logic [7:0] cj;
		ok = 1'b1;
		if (cfg.length < MIN_RADIX || cfg.length > MAX_RADIX) begin
			ok = 1'b0;
		end
		for (int i = 0; i < MAX_BASE; i++) begin
			ci = char_at(cfg, DIGIT_W'(i));
			if (LEN_W'(i) < cfg.length) begin
				if (ci == CHAR_PLUS || ci == CHAR_MINUS || ci <= CHAR_SPACE
						|| ci > CHAR_TILDE) begin
					ok = 1'b0;
				end
				for (int j = i + 1; j < MAX_BASE; j++) begin
					cj = char_at(cfg, DIGIT_W'(j));
					if (LEN_W'(j) < cfg.length && cj == ci) begin
						ok = 1'b0;
					end
				end
			end
		end
		return ok;
	endfunction

endpackage

>>> hw/rtl/sird_front.sv
// ----------------------------------------------------------------------------
// sird_front
// Accepts values, checks the alphabet and splits each value into sign and
// magnitude for the queue.
// ----------------------------------------------------------------------------
module sird_front import sird_pkg::*; (
	input  logic               start,
	input  logic               full,
	input  logic [VALUE_W-1:0] value,
	input  cfg_t               cfg,
	output logic               push,
	output item_t              item
);

	logic accept;

	assign accept   = start && !full;
	// Values taken under a bad alphabet produce no characters and are dropped.
	assign push     = accept && alphabet_ok(cfg);
	assign item.neg = value[VALUE_W-1];
	assign item.mag = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;

endmodule

>>> hw/rtl/sird_queue.sv
// ----------------------------------------------------------------------------
// sird_queue
// Two-entry queue of classified values between the front and back parts.
// ----------------------------------------------------------------------------
module sird_queue import sird_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> hw/rtl/sird_back.sv
// ----------------------------------------------------------------------------
// sird_back
// Converts one magnitude at a time by repeated bit-serial division by the
// radix, stores the digits and then emits the sign, if negative, and digits.
// ----------------------------------------------------------------------------
module sird_back import sird_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        empty,
	input  item_t       head,
	output logic        pop,
	output logic        result_valid,
	output logic [7:0]  character,
	output logic        is_sign,
	output logic        last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_SIGN  = 2'd2;
	localparam logic [1:0] ST_DIGIT = 2'd3;

	logic [1:0]         state_q;
	logic               neg_q;
	logic [VALUE_W-1:0] mag_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [DIDX_W-1:0]  bit_q;
	logic [DIDX_W:0]    wr_q;
	logic [DIDX_W-1:0]  idx_q;
	logic [DIGIT_W-1:0] digit_q [NUM_DIGITS];

	logic               result_valid_q;
	logic [7:0]         character_q;
	logic               is_sign_q;
	logic               last_q;

	logic [DIGIT_W:0]   rem_ext;
	logic               ge;
	logic [DIGIT_W:0]   rem_diff;
	logic [DIGIT_W-1:0] rem_next;
	logic [VALUE_W-1:0] quot_next;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign rem_ext  = {rem_q, mag_q[VALUE_W-1]};
	assign ge       = (rem_ext >= cfg.length);
	assign rem_diff = rem_ext - cfg.length;
	assign rem_next = ge ? rem_diff[DIGIT_W-1:0] : rem_ext[DIGIT_W-1:0];
	assign quot_next = {mag_q[VALUE_W-2:0], ge};

	assign result_valid = result_valid_q;
	assign character    = character_q;
	assign is_sign      = is_sign_q;
	assign last         = last_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && bit_q == DIDX_W'(0)) begin
			digit_q[wr_q[DIDX_W-1:0]] <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			neg_q          <= 1'b0;
			mag_q          <= '0;
			rem_q          <= '0;
			bit_q          <= '0;
			wr_q           <= '0;
			idx_q          <= '0;
			result_valid_q <= 1'b0;
			character_q    <= '0;
			is_sign_q      <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						neg_q   <= head.neg;
						mag_q   <= head.mag;
						rem_q   <= '0;
						bit_q   <= DIDX_W'(VALUE_W - 1);
						wr_q    <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					mag_q <= quot_next;
					if (bit_q == DIDX_W'(0)) begin
						rem_q <= '0;
						bit_q <= DIDX_W'(VALUE_W - 1);
						wr_q  <= wr_q + 1'b1;
						if (quot_next == '0) begin
							idx_q   <= wr_q[DIDX_W-1:0];
							state_q <= neg_q ? ST_SIGN : ST_DIGIT;
						end
					end else begin
						rem_q <= rem_next;
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_SIGN: begin
					result_valid_q <= 1'b1;
					character_q    <= CHAR_MINUS;
					is_sign_q      <= 1'b1;
					last_q         <= 1'b0;
					state_q        <= ST_DIGIT;
				end
				ST_DIGIT: begin
					result_valid_q <= 1'b1;
					character_q    <= char_at(cfg, digit_q[idx_q]);
					is_sign_q      <= 1'b0;
					last_q         <= (idx_q == DIDX_W'(0));
					if (idx_q == DIDX_W'(0)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/signed_integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Converts signed 32-bit values to text in a radix set by a configured
// alphabet of up to sixteen characters.
// ----------------------------------------------------------------------------
// Usage: a value is taken when start is high and busy is low. Each output
// character appears for one cycle with result_valid high; a negative value
// gives a leading '-' with is_sign set, and the final digit carries last.
// Zero gives the single first alphabet character. If the alphabet is invalid
// when a value is taken, the value is dropped and nothing is emitted.
// The alphabet is written over the cfg channel (index 0 length, 1 characters
// 0 to 7, 2 characters 8 to 15); cfg_ready is always high.
// Values wait in a two-entry queue; busy is high while it is full.
// The converter divides by the radix one quotient bit per cycle, one full
// pass over the magnitude per digit; a value occupies the converter until
// its last digit is found and then emits its characters on consecutive
// cycles, up to 33 of them in radix 2.
// Reset clears the alphabet registers, the queue and the converter.
// The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits import sird_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_W-1:0]    value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output logic [7:0]            character,
	output logic                  is_sign,
	output logic                  last
);

	cfg_t  cfg_q;
	logic  push;
	item_t push_item;
	logic  pop;
	item_t head;
	logic  empty;
	logic  full;

	assign cfg_ready = 1'b1;
	assign busy      = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LENGTH:     cfg_q.length     <= cfg_data[LEN_W-1:0];
				CFG_CHARS_LOW:  cfg_q.chars_low  <= cfg_data;
				CFG_CHARS_HIGH: cfg_q.chars_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sird_front u_front (
		.start (start),
		.full  (full),
		.value (value),
		.cfg   (cfg_q),
		.push  (push),
		.item  (push_item)
	);

	sird_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	sird_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.character    (character),
		.is_sign      (is_sign),
		.last         (last)
	);

`ifndef SYNTHESIS
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_sign |-> !last)
		else $error("Sign word marked as last.");

	a_sign_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_sign |=> result_valid && !is_sign)
		else $error("Sign word not followed by a digit.");

	a_digits_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid)
		else $error("Gap inside the characters of one value.");

	a_pop_only_when_filled: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("Queue read while empty.");
`endif

endmodule
